@@ rtl/assert_macros.svh @@
// Assertion macros shared by the solver RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("solver assertion failed");
`define SCC_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("solver invariant violated");
`else
`define SCC_ASSERT(lbl, prop)
`define SCC_CHECK(lbl, cond)
`endif
`endif

@@ rtl/scc_pkg.sv @@
// Types and constants for the 3x3 Cramer solver.
package scc_pkg;
  localparam int ElemW  = 32;
  localparam int NumIn  = 12;
  localparam int InW    = ElemW * NumIn;
  localparam int ProdW  = 2 * ElemW;
  localparam int CofW   = ProdW + 1;
  localparam int TermW  = ElemW + CofW;
  localparam int SumW   = TermW + 2;
  localparam int MagW   = 96;
  localparam int FracW  = 16;
  localparam int NumW   = MagW + FracW;
  localparam int RemW   = MagW + 1;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [SumW-1:0]  dsum_t;

  // Pair products, cofactor k = prod(2k) - prod(2k+1); matrix row-major a..i.
  localparam int PA [18] = '{4,5, 5,3, 3,4, 2,1, 0,2, 1,0, 1,2, 2,0, 0,1};
  localparam int PB [18] = '{8,7, 6,8, 7,6, 7,8, 8,6, 6,7, 5,4, 3,5, 4,3};
  // Expansion terms: multiplier (a,b,c,rhs1..3) and cofactor, three per sum.
  localparam int TX [12] = '{0,1,2, 3,4,5, 3,4,5, 3,4,5};
  localparam int TC [12] = '{0,1,2, 0,3,6, 1,4,7, 2,5,8};
endpackage

@@ rtl/solve_linear_3x3_cramer_core.sv @@
// Solves a 3x3 Q16.16 linear system by Cramer's rule; one request per cycle while the
// output is not stalled. Five stages form the nine cofactors and the four exact
// determinants, one stage takes magnitudes and signs, three 33-stage restoring dividers
// (a range precheck, then one quotient bit a stage) produce the solutions, and an output
// register holds the result. A singular matrix or a solution outside the Q16.16 range
// gives solved low and zero solutions. A stalled output freezes the whole pipeline;
// nothing is lost or repeated.
`include "assert_macros.svh"
module solve_linear_3x3_cramer_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // coef_r1_c1, coef_r1_c2, coef_r1_c3, coef_r2_c1 .. coef_r3_c3, rhs_1, rhs_2, rhs_3
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sol_1, sol_2, sol_3
  output logic [95:0]  out_tdata,
  // solved
  output logic         out_tuser
);
  import scc_pkg::*;

  logic               en;
  logic               dv;
  dsum_t              dsum [4];
  logic               mv_r;
  logic [MagW-1:0]    mden_r;
  logic [NumW-1:0]    mnum_r [3];
  logic               mneg_r [3];
  logic               mok_r;
  logic               qv   [3];
  logic [ElemW-1:0]   qq   [3];
  logic               qneg [3];
  logic               qok  [3];
  logic               ov_r;
  logic [ElemW-1:0]   sol_r [3];
  logic               solved_r;
  logic [ElemW-1:0]   sol_nxt [3];
  logic               solved_nxt;
  dsum_t              mag [4];

  assign en        = !ov_r || out_tready;
  assign in_tready = en;

  scc_det u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .out_valid (dv),
    .out_sum   (dsum)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = dsum[k][SumW-1] ? -dsum[k] : dsum[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mden_r <= mag[0][MagW-1:0];
      mok_r  <= dsum[0] != '0;
      for (int k = 0; k < 3; k++) begin
        mnum_r[k] <= {mag[k+1][MagW-1:0], FracW'(0)};
        mneg_r[k] <= dsum[0][SumW-1] ^ dsum[k+1][SumW-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    scc_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (mv_r),
      .in_num    (mnum_r[k]),
      .in_den    (mden_r),
      .in_neg    (mneg_r[k]),
      .in_ok     (mok_r),
      .out_valid (qv[k]),
      .out_quot  (qq[k]),
      .out_neg   (qneg[k]),
      .out_ok    (qok[k])
    );
  end

  // A negative result may reach -2^31; a positive one stops at 2^31 - 1.
  always_comb begin
    solved_nxt = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (!qok[k] || (qq[k][ElemW-1] && (!qneg[k] || (qq[k][ElemW-2:0] != '0)))) begin
        solved_nxt = 1'b0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      sol_nxt[k] = solved_nxt ? (qneg[k] ? -qq[k] : qq[k]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= qv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sol_r    <= sol_nxt;
      solved_r <= solved_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {sol_r[2], sol_r[1], sol_r[0]};
  assign out_tuser  = solved_r;

  `SCC_CHECK(a_fail_zero, !(ov_r && !solved_r) || (out_tdata == '0))
  `SCC_CHECK(a_lanes_agree, (qv[0] == qv[1]) && (qv[1] == qv[2]))
  `SCC_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
endmodule

@@ rtl/scc_det.sv @@
// Five-stage pipeline forming the system determinant and the three Cramer numerators.
`include "assert_macros.svh"
module scc_det (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [scc_pkg::InW-1:0]   in_data,
  output logic                      out_valid,
  output scc_pkg::dsum_t            out_sum [4]
);
  import scc_pkg::*;

  elem_t                   m [NumIn];
  logic                    v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [ProdW-1:0] p_r  [18];
  elem_t                   x1_r [6];
  logic signed [CofW-1:0]  c_r  [9];
  elem_t                   x2_r [6];
  logic signed [ProdW-1:0] ph_r [12];
  logic signed [ProdW+1:0] pl_r [12];
  logic signed [TermW-1:0] t_r  [12];
  dsum_t                   s_r  [4];

  always_comb begin
    for (int k = 0; k < NumIn; k++) begin
      m[k] = $signed(in_data[ElemW*k +: ElemW]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 18; k++) begin
        p_r[k] <= ProdW'(m[PA[k]]) * ProdW'(m[PB[k]]);
      end
      for (int k = 0; k < 3; k++) begin
        x1_r[k]     <= m[k];
        x1_r[k + 3] <= m[9 + k];
      end
      for (int k = 0; k < 9; k++) begin
        c_r[k] <= CofW'(p_r[2*k]) - CofW'(p_r[2*k + 1]);
      end
      x2_r <= x1_r;
      // Each cofactor is split into a signed upper 32-bit part and an unsigned lower 33-bit part.
      for (int k = 0; k < 12; k++) begin
        ph_r[k] <= ProdW'(x2_r[TX[k]]) * ProdW'($signed(c_r[TC[k]][CofW-1:33]));
        pl_r[k] <= (ProdW+2)'(x2_r[TX[k]]) * (ProdW+2)'($signed({1'b0, c_r[TC[k]][32:0]}));
      end
      for (int k = 0; k < 12; k++) begin
        t_r[k] <= (TermW'(ph_r[k]) <<< 33) + TermW'(pl_r[k]);
      end
      for (int g = 0; g < 4; g++) begin
        s_r[g] <= SumW'(t_r[3*g]) + SumW'(t_r[3*g + 1]) + SumW'(t_r[3*g + 2]);
      end
    end
  end

  assign out_valid = v5_r;
  assign out_sum   = s_r;

  `SCC_ASSERT(a_enter, (en && in_valid) |=> v1_r)
  `SCC_ASSERT(a_hold, (!en) |=> (v5_r == $past(v5_r)))
endmodule

@@ rtl/scc_div.sv @@
// Pipelined restoring divider: 32 quotient bits, one per stage, with an overflow precheck.
`include "assert_macros.svh"
module scc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [scc_pkg::NumW-1:0]   in_num,
  input  logic [scc_pkg::MagW-1:0]   in_den,
  input  logic                       in_neg,
  input  logic                       in_ok,
  output logic                       out_valid,
  output logic [scc_pkg::ElemW-1:0]  out_quot,
  output logic                       out_neg,
  output logic                       out_ok
);
  import scc_pkg::*;

  localparam int Steps = ElemW;

  logic              v_r   [Steps+1];
  logic [RemW-1:0]   r_r   [Steps+1];
  logic [ElemW-1:0]  nlo_r [Steps+1];
  logic [ElemW-1:0]  q_r   [Steps+1];
  logic [MagW-1:0]   den_r [Steps+1];
  logic              neg_r [Steps+1];
  logic              ok_r  [Steps+1];

  // A quotient of 2^32 or more shows up as an upper numerator not below the divisor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= RemW'(in_num[NumW-1:ElemW]);
      nlo_r[0] <= in_num[ElemW-1:0];
      q_r[0]   <= '0;
      den_r[0] <= in_den;
      neg_r[0] <= in_neg;
      ok_r[0]  <= in_ok && (RemW'(in_num[NumW-1:ElemW]) < RemW'(in_den));
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [RemW-1:0] sh;
    logic            ge;
    always_comb begin
      sh = {r_r[k][RemW-2:0], nlo_r[k][ElemW-1]};
      ge = sh >= {1'b0, den_r[k]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1]   <= ge ? sh - {1'b0, den_r[k]} : sh;
        nlo_r[k+1] <= {nlo_r[k][ElemW-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][ElemW-2:0], ge};
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ok_r[k+1]  <= ok_r[k];
      end
    end
  end

  assign out_valid = v_r[Steps];
  assign out_quot  = q_r[Steps];
  assign out_neg   = neg_r[Steps];
  assign out_ok    = ok_r[Steps];

  `SCC_CHECK(a_rem_bound, !(v_r[Steps] && ok_r[Steps]) || (r_r[Steps] < {1'b0, den_r[Steps]}))
  `SCC_ASSERT(a_ok_kept, (en && v_r[0] && !ok_r[0]) |=> !ok_r[1])
endmodule

@@ sim/scc_checker.sv @@
// Checker for the 3x3 Cramer solver: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module scc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [383:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending_count
);
  import scc_pkg::*;

  typedef struct packed {
    logic        solved;
    logic [31:0] sol_3;
    logic [31:0] sol_2;
    logic [31:0] sol_1;
  } solution_t;

  solution_t solutions_due[$];

  function automatic logic signed [127:0] det_of(logic signed [127:0] m [9]);
    return m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
         - m[2]*m[4]*m[6] - m[1]*m[3]*m[8] - m[0]*m[5]*m[7];
  endfunction

  // Exact Cramer solution; quotients truncate toward zero before the range test.
  function automatic solution_t solve_system(logic [383:0] req);
    logic signed [127:0] a [9];
    logic signed [127:0] t [9];
    logic signed [127:0] rhs [3];
    logic signed [127:0] den, num, q;
    logic [127:0] nmag, dmag, qmag;
    logic [31:0] x [3];
    logic ok;
    solution_t r;
    for (int i = 0; i < 9; i++) a[i] = 128'(elem_t'(req[32*i +: 32]));
    for (int i = 0; i < 3; i++) rhs[i] = 128'(elem_t'(req[32*(9+i) +: 32]));
    den = det_of(a);
    ok = (den != 0);
    for (int k = 0; k < 3; k++) begin
      x[k] = '0;
      if (ok) begin
        t = a;
        for (int i = 0; i < 3; i++) t[3*i+k] = rhs[i];
        num = det_of(t);
        nmag = (num < 0) ? -num : num;
        dmag = (den < 0) ? -den : den;
        qmag = (nmag << 16) / dmag;
        q = ((num < 0) != (den < 0)) ? -$signed(qmag) : $signed(qmag);
        if (q > 128'sh7FFF_FFFF || q < -128'sh8000_0000) ok = 1'b0;
        else x[k] = q[31:0];
      end
    end
    r.solved = ok;
    r.sol_1 = ok ? x[0] : '0;
    r.sol_2 = ok ? x[1] : '0;
    r.sol_3 = ok ? x[2] : '0;
    return r;
  endfunction

  assign pending_count = solutions_due.size();

  always @(posedge clk) begin
    solution_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) solutions_due.push_back(solve_system(in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (solutions_due.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = solutions_due.pop_front();
          if (got != want) begin
            if (got.sol_1 != want.sol_1)
              $error("sol_1 expected %h actual %h", want.sol_1, got.sol_1);
            if (got.sol_2 != want.sol_2)
              $error("sol_2 expected %h actual %h", want.sol_2, got.sol_2);
            if (got.sol_3 != want.sol_3)
              $error("sol_3 expected %h actual %h", want.sol_3, got.sol_3);
            if (got.solved != want.solved)
              $error("solved expected %b actual %b", want.solved, got.solved);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ sim/tb_solve_linear_3x3_cramer_core.sv @@
// Stimulus and verdict for the 3x3 Cramer solver core.
`timescale 1ns / 100ps
module tb_solve_linear_3x3_cramer_core;
  localparam int OneQ = 32'h0001_0000;
  localparam int WatchdogLimit = 20000;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [383:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic         out_tuser;
  int           fail_count, pending_count;
  int           idle_cycles = 0;
  int           sink_gap = 0;
  logic         sink_run = 1'b0;

  solve_linear_3x3_cramer_core i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  scc_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count, .pending_count
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? OneQ : -OneQ;
      3: return $urandom_range(0, 15) * OneQ - 8 * OneQ;
      4: return $urandom;
      default: return int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  // Random requests; some have a repeated row or column to force singular cases, some are identity.
  function automatic logic [383:0] rand_request();
    logic [383:0] r;
    for (int i = 0; i < 12; i++) r[32*i +: 32] = rand_elem();
    case ($urandom_range(0, 9))
      0: r[96 +: 96] = r[0 +: 96];
      1: for (int i = 0; i < 3; i++) r[32*(3*i+2) +: 32] = r[32*(3*i) +: 32];
      2: for (int i = 0; i < 9; i++) r[32*i +: 32] = (i % 4 == 0) ? OneQ : 32'h0;
      default: ;
    endcase
    return r;
  endfunction

  // Valid stays high between back-to-back requests and drops only for a gap.
  task automatic send(logic [383:0] req);
    int g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tdata  <= req;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [383:0] diag(logic [31:0] v, logic [31:0] b);
    logic [383:0] r = '0;
    for (int i = 0; i < 9; i += 4) r[32*i +: 32] = v;
    for (int i = 9; i < 12; i++) r[32*i +: 32] = b;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!sink_run) begin
      out_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap   <= sink_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < 20) sink_gap <= gap_len();
    end
  end

  // Watchdog: cycles with no transfer accepted on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [383:0] req;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    sink_run <= 1'b1;
    // Directed part: identity, scaling, extremes, singular and overflow cases.
    send(diag(OneQ, OneQ));
    send(diag(OneQ, 32'h8000_0000));
    send(diag(OneQ, 32'h7FFF_FFFF));
    send(diag(-OneQ, 32'h8000_0000));
    send(diag(32'h0000_0001, OneQ));
    send(diag(32'h8000_0000, 32'h8000_0000));
    send(diag(32'h7FFF_FFFF, 32'h8000_0000));
    send(diag(32'h8000_0000, 32'h7FFF_FFFF));
    send('0);
    send({12{32'hFFFF_FFFF}});
    send({12{32'h8000_0000}});
    send({12{32'h7FFF_FFFF}});
    req = diag(OneQ, OneQ); req[32 +: 32] = 32'h8000_0000; req[5*32 +: 32] = 32'h7FFF_FFFF;
    send(req);
    req = diag(2 * OneQ, 32'hFFFF_0000); req[2*32 +: 32] = OneQ;
    send(req);
    req = '0;
    req[0 +: 32] = 32'h7FFF_FFFF; req[4*32 +: 32] = 32'h8000_0000; req[8*32 +: 32] = 32'h7FFF_FFFF;
    req[32 +: 32] = 32'h8000_0000; req[3*32 +: 32] = 32'h7FFF_FFFF; req[9*32 +: 96] = {3{32'h5555_AAAA}};
    send(req);
    req = diag(OneQ, 32'hAAAA_5555); req[4*32 +: 32] = 32'hFFFF_FFFF;
    send(req);
    for (int i = 0; i < 1800; i++) send(rand_request());
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
